/* hw/rtl/arq_receive_reorder_window_top_defines.svh */
// Assertion helpers shared by the receive reorder window modules.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef ARQ_RECEIVE_REORDER_WINDOW_TOP_DEFINES_SVH
`define ARQ_RECEIVE_REORDER_WINDOW_TOP_DEFINES_SVH

// Same-cycle implication.
`define ARQRW_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arqrw: same-cycle check failed");

// Next-cycle implication.
`define ARQRW_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arqrw: next-cycle check failed");

`endif

/* hw/rtl/arqrw_pkg.sv */
package arqrw_pkg;

    localparam int OUT_SEQ_W = 16;
    localparam int GAP_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 6;
    localparam logic [GAP_W-1:0] GAP_SAT = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_ARQ_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_WINDOW  = 1'd1;

    localparam logic [CFG_DAT_W-1:0] RX_WINDOW_RESET = 6'd1;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_DROP    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        VERDICT_NEW    = 2'd0,
        VERDICT_DUP    = 2'd1,
        VERDICT_BEYOND = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DRAIN,
        ST_ACK,
        ST_DROP,
        ST_WALK,
        ST_TAIL
    } t_state;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLASSIFY,
        DP_DRAIN,
        DP_ACK,
        DP_DROP,
        DP_WALK,
        DP_TAIL
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic     out_free;
        logic     arq_on;
        logic     seq_old;
        t_verdict verdict_now;
        t_verdict verdict_q;
        logic     head_held;
        logic     walk_last;
        logic     walk_tail;
    } t_dp_sts;

endpackage

/* hw/rtl/arq_receive_reorder_window_top.sv */
// Flow: a packet is registered on acceptance and classified; its results are then registered
// in order, and output back-pressure holds the sequence until each result is taken.
// Windowed mode gives up to WINDOW_MAX + 1 results: deliveries, an ACK, a drop if not new.
// Plain mode gives one drop, or scans the window offsets in order up to the last held number
// and delivers them merged with the received number; a new packet is taken only when idle.
// Reset: controller idle, next expected number 1, held bitmap clear, ARQ on, window 1.
module arq_receive_reorder_window_top #(
    parameter int WINDOW_MAX = 32,
    parameter int SEQ_WIDTH  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [arqrw_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [arqrw_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [SEQ_WIDTH-1:0]            i_seq_num,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_kind,
    output logic [arqrw_pkg::OUT_SEQ_W-1:0] o_out_seq,
    output logic [1:0]                      o_verdict,
    output logic [arqrw_pkg::GAP_W-1:0]     o_lost_gap,
    output logic                            o_last
);

    arqrw_pkg::t_dp_cmd cmd;
    arqrw_pkg::t_dp_sts sts;

    arqrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    arqrw_dpath #(
        .WINDOW_MAX (WINDOW_MAX),
        .SEQ_WIDTH  (SEQ_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_seq_num   (i_seq_num),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_out_seq   (o_out_seq),
        .o_verdict   (o_verdict),
        .o_lost_gap  (o_lost_gap),
        .o_last      (o_last)
    );

endmodule

/* hw/rtl/arqrw_ctrl.sv */
`include "arq_receive_reorder_window_top_defines.svh"

module arqrw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  arqrw_pkg::t_dp_sts i_sts,
    output arqrw_pkg::t_dp_cmd o_cmd
);

    arqrw_pkg::t_state r_state;
    arqrw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arqrw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arqrw_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = arqrw_pkg::ST_CLASSIFY;
                end
            end
            arqrw_pkg::ST_CLASSIFY: begin
                if (!i_sts.arq_on) begin
                    n_state = i_sts.seq_old ? arqrw_pkg::ST_DROP : arqrw_pkg::ST_WALK;
                end else if (i_sts.verdict_now == arqrw_pkg::VERDICT_NEW) begin
                    n_state = arqrw_pkg::ST_DRAIN;
                end else begin
                    n_state = arqrw_pkg::ST_ACK;
                end
            end
            arqrw_pkg::ST_DRAIN: begin
                // the closing ACK of a new packet ends the item
                if (i_sts.out_free && !i_sts.head_held) begin
                    n_state = arqrw_pkg::ST_IDLE;
                end
            end
            arqrw_pkg::ST_ACK: begin
                if (i_sts.out_free) begin
                    n_state = arqrw_pkg::ST_DROP;
                end
            end
            arqrw_pkg::ST_DROP: begin
                if (i_sts.out_free) begin
                    n_state = arqrw_pkg::ST_IDLE;
                end
            end
            arqrw_pkg::ST_WALK: begin
                if (i_sts.out_free) begin
                    if (i_sts.walk_last) begin
                        n_state = arqrw_pkg::ST_IDLE;
                    end else if (i_sts.walk_tail) begin
                        n_state = arqrw_pkg::ST_TAIL;
                    end
                end
            end
            arqrw_pkg::ST_TAIL: begin
                if (i_sts.out_free) begin
                    n_state = arqrw_pkg::ST_IDLE;
                end
            end
            default: n_state = arqrw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.op        = arqrw_pkg::DP_NOP;
        o_cmd.emit_last = 1'b0;
        unique case (r_state)
            arqrw_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = arqrw_pkg::DP_LOAD;
                end
            end
            arqrw_pkg::ST_CLASSIFY: begin
                o_cmd.op = arqrw_pkg::DP_CLASSIFY;
            end
            arqrw_pkg::ST_DRAIN: begin
                if (i_sts.out_free) begin
                    if (i_sts.head_held) begin
                        o_cmd.op = arqrw_pkg::DP_DRAIN;
                    end else begin
                        o_cmd.op        = arqrw_pkg::DP_ACK;
                        o_cmd.emit_last = 1'b1;
                    end
                end
            end
            arqrw_pkg::ST_ACK: begin
                if (i_sts.out_free) begin
                    o_cmd.op = arqrw_pkg::DP_ACK;
                end
            end
            arqrw_pkg::ST_DROP: begin
                if (i_sts.out_free) begin
                    o_cmd.op        = arqrw_pkg::DP_DROP;
                    o_cmd.emit_last = 1'b1;
                end
            end
            arqrw_pkg::ST_WALK: begin
                if (i_sts.out_free) begin
                    o_cmd.op        = arqrw_pkg::DP_WALK;
                    o_cmd.emit_last = i_sts.walk_last;
                end
            end
            arqrw_pkg::ST_TAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.op        = arqrw_pkg::DP_TAIL;
                    o_cmd.emit_last = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // a fully drained window never leaves the expected number held
    `ARQRW_ASSERT_NOW(a_head_clear_idle, r_state == arqrw_pkg::ST_IDLE, !i_sts.head_held)
    `ARQRW_ASSERT_NOW(a_walk_end_excl, r_state == arqrw_pkg::ST_WALK, !(i_sts.walk_last && i_sts.walk_tail))

endmodule

/* hw/rtl/arqrw_dpath.sv */
`include "arq_receive_reorder_window_top_defines.svh"

module arqrw_dpath #(
    parameter int WINDOW_MAX = 32,
    parameter int SEQ_WIDTH  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [arqrw_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [arqrw_pkg::CFG_DAT_W-1:0]     i_cfg_wdata,
    input  logic [SEQ_WIDTH-1:0]                i_seq_num,
    input  arqrw_pkg::t_dp_cmd                  i_cmd,
    output arqrw_pkg::t_dp_sts                  o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [1:0]                          o_kind,
    output logic [arqrw_pkg::OUT_SEQ_W-1:0]     o_out_seq,
    output logic [1:0]                          o_verdict,
    output logic [arqrw_pkg::GAP_W-1:0]         o_lost_gap,
    output logic                                o_last
);

    localparam int OFF_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam logic [arqrw_pkg::CFG_DAT_W-1:0] WIN_CAP = arqrw_pkg::CFG_DAT_W'(WINDOW_MAX);

    // configuration
    logic                              r_arq_en;
    logic [arqrw_pkg::CFG_DAT_W-1:0]   r_rx_win;

    // window state
    logic [SEQ_WIDTH-1:0]  r_ne;
    logic [WINDOW_MAX-1:0] r_map;

    // per-item working registers
    logic [SEQ_WIDTH-1:0]  r_seq;
    arqrw_pkg::t_verdict   r_verdict;
    logic [OFF_W-1:0]      r_off;
    logic                  r_done;
    logic [SEQ_WIDTH:0]    r_cur;

    // output stage
    logic                           r_out_valid;
    arqrw_pkg::t_kind               r_kind;
    logic [arqrw_pkg::OUT_SEQ_W-1:0] r_out_seq;
    arqrw_pkg::t_verdict            r_out_verdict;
    logic [arqrw_pkg::GAP_W-1:0]    r_gap;
    logic                           r_last;

    logic [arqrw_pkg::CFG_DAT_W-1:0] win_eff;
    logic [SEQ_WIDTH-1:0]  seq_dist;
    logic [OFF_W-1:0]      dist_idx;
    logic                  seq_old;
    arqrw_pkg::t_verdict   verdict_now;
    logic                  out_free;

    logic                  hit_seq;
    logic                  walk_emit;
    logic                  done_nx;
    logic [WINDOW_MAX-1:0] map_rest;
    logic                  rest_zero;
    logic [SEQ_WIDTH:0]    walk_addr;
    logic [SEQ_WIDTH:0]    tail_addr;
    logic [SEQ_WIDTH:0]    dlv_addr;
    logic [SEQ_WIDTH:0]    dlv_next;
    logic [SEQ_WIDTH:0]    gap_raw;
    logic [SEQ_WIDTH+16:0] gap_ext;
    logic [arqrw_pkg::GAP_W-1:0] gap_sat;
    logic [SEQ_WIDTH+15:0] dlv_ext;
    logic [SEQ_WIDTH+15:0] ne_ext;
    logic [SEQ_WIDTH+15:0] seq_ext;
    logic                  emit;

    assign win_eff  = (r_rx_win > WIN_CAP) ? WIN_CAP : r_rx_win;
    assign seq_old  = (r_seq < r_ne);
    assign seq_dist = r_seq - r_ne;
    assign dist_idx = seq_dist[OFF_W-1:0];

    always_comb begin
        if (seq_old) begin
            verdict_now = arqrw_pkg::VERDICT_DUP;
        end else if (seq_dist >= SEQ_WIDTH'(win_eff)) begin
            verdict_now = arqrw_pkg::VERDICT_BEYOND;
        end else if (r_map[dist_idx]) begin
            verdict_now = arqrw_pkg::VERDICT_DUP;
        end else begin
            verdict_now = arqrw_pkg::VERDICT_NEW;
        end
    end

    // plain-mode scan: one window offset per step
    assign hit_seq   = !r_done && (seq_dist == SEQ_WIDTH'(r_off));
    assign walk_emit = hit_seq || r_map[0];
    assign done_nx   = r_done || hit_seq;
    assign map_rest  = r_map >> 1;
    assign rest_zero = (map_rest == '0);
    assign walk_addr = {1'b0, r_ne} + (SEQ_WIDTH+1)'(r_off);
    assign tail_addr = {1'b0, r_seq};
    assign dlv_addr  = (i_cmd.op == arqrw_pkg::DP_TAIL) ? tail_addr : walk_addr;
    assign dlv_next  = dlv_addr + (SEQ_WIDTH+1)'(1);
    assign gap_raw   = dlv_addr - r_cur;
    assign gap_ext   = {16'b0, gap_raw};
    assign gap_sat   = (|gap_ext[SEQ_WIDTH+16:16]) ? arqrw_pkg::GAP_SAT : gap_ext[15:0];
    assign dlv_ext   = {16'b0, dlv_addr[SEQ_WIDTH-1:0]};
    assign ne_ext    = {16'b0, r_ne};
    assign seq_ext   = {16'b0, r_seq};

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_cmd.op)
            arqrw_pkg::DP_DRAIN, arqrw_pkg::DP_ACK, arqrw_pkg::DP_DROP,
            arqrw_pkg::DP_TAIL: emit = 1'b1;
            arqrw_pkg::DP_WALK: emit = walk_emit;
            default:            emit = 1'b0;
        endcase
    end

    assign o_sts.out_free    = out_free;
    assign o_sts.arq_on      = r_arq_en;
    assign o_sts.seq_old     = seq_old;
    assign o_sts.verdict_now = verdict_now;
    assign o_sts.verdict_q   = r_verdict;
    assign o_sts.head_held   = r_map[0];
    assign o_sts.walk_last   = rest_zero && done_nx;
    assign o_sts.walk_tail   = rest_zero && !done_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arq_en <= 1'b1;
            r_rx_win <= arqrw_pkg::RX_WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                arqrw_pkg::CFG_ARQ_ENABLE: r_arq_en <= i_cfg_wdata[0];
                arqrw_pkg::CFG_RX_WINDOW:  r_rx_win <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne  <= SEQ_WIDTH'(1);
            r_map <= '0;
        end else begin
            case (i_cmd.op)
                arqrw_pkg::DP_CLASSIFY: begin
                    if (r_arq_en && verdict_now == arqrw_pkg::VERDICT_NEW) begin
                        r_map[dist_idx] <= 1'b1;
                    end
                end
                arqrw_pkg::DP_DRAIN: begin
                    // advance past the delivered head
                    r_ne  <= r_ne + SEQ_WIDTH'(1);
                    r_map <= map_rest;
                end
                arqrw_pkg::DP_WALK: begin
                    r_map <= map_rest;
                    if (rest_zero && done_nx) begin
                        r_ne <= dlv_next[SEQ_WIDTH-1:0];
                    end
                end
                arqrw_pkg::DP_TAIL: begin
                    r_ne <= dlv_next[SEQ_WIDTH-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            arqrw_pkg::DP_LOAD: begin
                r_seq <= i_seq_num;
            end
            arqrw_pkg::DP_CLASSIFY: begin
                r_verdict <= verdict_now;
                r_off     <= '0;
                r_done    <= 1'b0;
                r_cur     <= {1'b0, r_ne};
            end
            arqrw_pkg::DP_WALK: begin
                r_off  <= r_off + OFF_W'(1);
                r_done <= done_nx;
                if (walk_emit) begin
                    r_cur <= dlv_next;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_last <= i_cmd.emit_last;
            case (i_cmd.op)
                arqrw_pkg::DP_DRAIN: begin
                    r_kind        <= arqrw_pkg::KIND_DELIVER;
                    r_out_seq     <= ne_ext[15:0];
                    r_out_verdict <= arqrw_pkg::VERDICT_NEW;
                    r_gap         <= '0;
                end
                arqrw_pkg::DP_ACK: begin
                    r_kind        <= arqrw_pkg::KIND_ACK;
                    r_out_seq     <= ne_ext[15:0];
                    r_out_verdict <= r_verdict;
                    r_gap         <= '0;
                end
                arqrw_pkg::DP_DROP: begin
                    r_kind        <= arqrw_pkg::KIND_DROP;
                    r_out_seq     <= seq_ext[15:0];
                    r_out_verdict <= r_verdict;
                    r_gap         <= '0;
                end
                default: begin
                    r_kind        <= arqrw_pkg::KIND_DELIVER;
                    r_out_seq     <= dlv_ext[15:0];
                    r_out_verdict <= arqrw_pkg::VERDICT_NEW;
                    r_gap         <= gap_sat;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_seq   = r_out_seq;
    assign o_verdict   = r_out_verdict;
    assign o_lost_gap  = r_gap;
    assign o_last      = r_last;

    `ARQRW_ASSERT_NOW(a_no_overwrite, r_out_valid && !i_out_ready, !emit)
    `ARQRW_ASSERT_NEXT(a_drain_advance, i_cmd.op == arqrw_pkg::DP_DRAIN, r_ne == $past(r_ne) + SEQ_WIDTH'(1))
    `ARQRW_ASSERT_NOW(a_tail_pending, i_cmd.op == arqrw_pkg::DP_TAIL, !r_done && (r_map == '0))

endmodule

/* verif/testbench.sv */
module testbench;

    localparam int WIN_MAX   = 32;
    localparam int SEQ_TOP   = 65535;
    localparam int N_PHASES  = 12;
    localparam int PHASE_LEN = 20;
    localparam int HOLD_LEN  = 400;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [arqrw_pkg::CFG_IDX_W-1:0] cfg_addr;
    logic [arqrw_pkg::CFG_DAT_W-1:0] cfg_wdata;
    logic                            pkt_valid;
    logic [15:0]                     pkt_seq;
    logic                            res_ready;
    logic                            pkt_ready;
    logic                            res_valid;
    logic [1:0]                      res_kind;
    logic [arqrw_pkg::OUT_SEQ_W-1:0] res_seq;
    logic [1:0]                      res_verdict;
    logic [arqrw_pkg::GAP_W-1:0]     res_gap;
    logic                            res_last;

    arq_receive_reorder_window_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (pkt_valid),
        .o_in_ready  (pkt_ready),
        .i_seq_num   (pkt_seq),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_kind      (res_kind),
        .o_out_seq   (res_seq),
        .o_verdict   (res_verdict),
        .o_lost_gap  (res_gap),
        .o_last      (res_last)
    );

    typedef struct {
        arqrw_pkg::t_kind            kind;
        logic [15:0]                 seq;
        arqrw_pkg::t_verdict         verdict;
        logic [arqrw_pkg::GAP_W-1:0] gap;
        logic                        last;
    } t_rx_event;

    // Tracks the receiver window and queues the events each packet must produce.
    class arq_rx_tracker;
        logic                            arq_on;
        logic [arqrw_pkg::CFG_DAT_W-1:0] win_reg;
        logic [15:0]                     next_exp;
        logic [WIN_MAX-1:0]              held;
        t_rx_event                       pending[$];
        int mismatches;
        int packets;
        int deliveries;
        int acks;
        int drops;
        int longest_burst;
        int cfg_writes;

        function new();
            arq_on        = 1'b1;
            win_reg       = arqrw_pkg::RX_WINDOW_RESET;
            next_exp      = 16'd1;
            held          = '0;
            mismatches    = 0;
            packets       = 0;
            deliveries    = 0;
            acks          = 0;
            drops         = 0;
            longest_burst = 0;
            cfg_writes    = 0;
        endfunction

        function void write_reg(logic [arqrw_pkg::CFG_IDX_W-1:0] idx,
                                logic [arqrw_pkg::CFG_DAT_W-1:0] val);
            cfg_writes++;
            if (idx == arqrw_pkg::CFG_ARQ_ENABLE)
                arq_on = val[0];
            else if (idx == arqrw_pkg::CFG_RX_WINDOW)
                win_reg = val;
        endfunction

        function int eff_window();
            return (win_reg > WIN_MAX) ? WIN_MAX : int'(win_reg);
        endfunction

        function void emit(arqrw_pkg::t_kind k, int s, arqrw_pkg::t_verdict v, int gap);
            t_rx_event r;
            r.kind    = k;
            r.seq     = s[15:0];
            r.verdict = v;
            r.gap     = (gap > SEQ_TOP) ? arqrw_pkg::GAP_SAT : gap[arqrw_pkg::GAP_W-1:0];
            r.last    = 1'b0;
            pending.push_back(r);
            case (k)
                arqrw_pkg::KIND_DELIVER: deliveries++;
                arqrw_pkg::KIND_ACK:     acks++;
                default:                 drops++;
            endcase
        endfunction

        function void accept_packet(logic [15:0] s);
            int                  w, d, a, cur, base, o, n0;
            bit                  done;
            arqrw_pkg::t_verdict v;
            t_rx_event           r;
            n0 = pending.size();
            packets++;
            w = eff_window();
            if (arq_on) begin
                if (s < next_exp) begin
                    v = arqrw_pkg::VERDICT_DUP;
                end else begin
                    d = int'(s) - int'(next_exp);
                    if (d >= w)
                        v = arqrw_pkg::VERDICT_BEYOND;
                    else if (held[d])
                        v = arqrw_pkg::VERDICT_DUP;
                    else
                        v = arqrw_pkg::VERDICT_NEW;
                    if (v == arqrw_pkg::VERDICT_NEW) begin
                        held[d] = 1'b1;
                        // deliver the contiguous run from the head of the window
                        while (held[0]) begin
                            emit(arqrw_pkg::KIND_DELIVER, int'(next_exp),
                                 arqrw_pkg::VERDICT_NEW, 0);
                            next_exp = next_exp + 16'd1;
                            held     = held >> 1;
                        end
                    end
                end
                emit(arqrw_pkg::KIND_ACK, int'(next_exp), v, 0);
                if (v != arqrw_pkg::VERDICT_NEW)
                    emit(arqrw_pkg::KIND_DROP, int'(s), v, 0);
            end else if (s < next_exp) begin
                emit(arqrw_pkg::KIND_DROP, int'(s), arqrw_pkg::VERDICT_DUP, 0);
            end else begin
                // merge the received number into the held numbers, ascending
                d    = int'(s) - int'(next_exp);
                base = int'(next_exp);
                cur  = base;
                done = 1'b0;
                for (o = 0; o < WIN_MAX; o++) begin
                    if (!done && d <= o) begin
                        a = base + d;
                        emit(arqrw_pkg::KIND_DELIVER, a, arqrw_pkg::VERDICT_NEW, a - cur);
                        cur  = a + 1;
                        done = 1'b1;
                        if (d == o)
                            continue;
                    end
                    if (held[o]) begin
                        a = base + o;
                        emit(arqrw_pkg::KIND_DELIVER, a, arqrw_pkg::VERDICT_NEW, a - cur);
                        cur = a + 1;
                    end
                end
                if (!done) begin
                    a = base + d;
                    emit(arqrw_pkg::KIND_DELIVER, a, arqrw_pkg::VERDICT_NEW, a - cur);
                    cur = a + 1;
                end
                held     = '0;
                next_exp = cur[15:0];
            end
            r      = pending.pop_back();
            r.last = 1'b1;
            pending.push_back(r);
            if (pending.size() - n0 > longest_burst)
                longest_burst = pending.size() - n0;
        endfunction

        function void check_result(logic [1:0] k, logic [15:0] s, logic [1:0] v,
                                   logic [arqrw_pkg::GAP_W-1:0] g, logic l);
            t_rx_event r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat kind=%0d seq=%0d verdict=%0d gap=%0d last=%0d",
                             $realtime, k, s, v, g, l);
                return;
            end
            r = pending.pop_front();
            if (k !== r.kind || s !== r.seq || v !== r.verdict || g !== r.gap
                || l !== r.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch exp kind=%0d seq=%0d verdict=%0d gap=%0d last=%0d",
                             $realtime, r.kind, r.seq, r.verdict, r.gap, r.last);
                    $display("%0t:          got kind=%0d seq=%0d verdict=%0d gap=%0d last=%0d",
                             $realtime, k, s, v, g, l);
                end
            end
        endfunction
    endclass

    arq_rx_tracker sb = new();
    logic [15:0]   traffic_q[$];
    bit            idle_on;
    int            hold_left;
    int            worst_stall;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function int pick_gap();
        if (!idle_on || $urandom_range(99) >= 20)
            return 0;
        return $urandom_range(1, 4);
    endfunction

    // Result side: random back-pressure plus one long hold-off on request.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_ready <= 1'b0;
        end else begin
            res_ready <= !idle_on || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res_kind, res_seq, res_verdict, res_gap, res_last);
    end

    task automatic send_seq(input logic [15:0] s);
        int gap;
        int stall;
        stall = 0;
        @(negedge clk);
        pkt_valid <= 1'b1;
        pkt_seq   <= s;
        @(posedge clk);
        while (!pkt_ready) begin
            stall++;
            @(posedge clk);
        end
        sb.accept_packet(s);
        if (stall > worst_stall)
            worst_stall = stall;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            pkt_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid, then hold until every queued event has come out.
    task automatic wait_drain();
        @(negedge clk);
        pkt_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [arqrw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [arqrw_pkg::CFG_DAT_W-1:0] val);
        wait_drain();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    function int clip_seq(int s);
        return (s > SEQ_TOP) ? SEQ_TOP : s;
    endfunction

    // Queue the next stretch of traffic, shaped around the current window.
    function void plan_traffic();
        int w, ne, pick, len, j, k, tmp;
        bit skip_head;
        int offs[WIN_MAX];
        w    = sb.eff_window();
        ne   = int'(sb.next_exp);
        pick = $urandom_range(99);
        if (sb.arq_on) begin
            if (pick < 70 && w > 0) begin
                len = ($urandom_range(99) < 30) ? w : $urandom_range(1, w);
                for (j = 0; j < len; j++)
                    offs[j] = j;
                for (j = len - 1; j > 0; j--) begin
                    k       = $urandom_range(0, j);
                    tmp     = offs[j];
                    offs[j] = offs[k];
                    offs[k] = tmp;
                end
                // head last releases the whole run in one go
                if ($urandom_range(99) < 40) begin
                    for (j = 0; j < len; j++)
                        if (offs[j] == 0) k = j;
                    offs[k]       = offs[len-1];
                    offs[len-1]   = 0;
                end
                skip_head = (len > 1) && ($urandom_range(99) < 25);
                for (j = 0; j < len; j++) begin
                    if (!(skip_head && offs[j] == 0))
                        traffic_q.push_back(16'(clip_seq(ne + offs[j])));
                    if ($urandom_range(99) < 8)
                        traffic_q.push_back(16'(clip_seq(ne + offs[$urandom_range(0, j)])));
                end
            end else if (pick < 82 && ne > 0) begin
                traffic_q.push_back(16'(ne - 1 - int'($urandom_range(0,
                                                       (ne > 40) ? 40 : ne - 1))));
            end else if (pick < 94) begin
                traffic_q.push_back(16'(clip_seq(ne + w + int'($urandom_range(0, 8)))));
            end else begin
                traffic_q.push_back(16'($urandom_range(0, SEQ_TOP)));
            end
        end else begin
            if (pick < 75)
                traffic_q.push_back(16'(clip_seq(ne + int'($urandom_range(0, 40)))));
            else if (pick < 90 && ne > 0)
                traffic_q.push_back(16'($urandom_range(0, ne - 1)));
            else
                traffic_q.push_back(16'($urandom_range(0, SEQ_TOP)));
        end
    endfunction

    task automatic run_phase(input bit arq, input int win, input int count);
        int sent;
        write_reg(arqrw_pkg::CFG_ARQ_ENABLE, arqrw_pkg::CFG_DAT_W'(arq));
        write_reg(arqrw_pkg::CFG_RX_WINDOW, arqrw_pkg::CFG_DAT_W'(win));
        sent = 0;
        while (sent < count || traffic_q.size() != 0) begin
            if (traffic_q.size() == 0)
                plan_traffic();
            send_seq(traffic_q.pop_front());
            sent++;
        end
    endtask

    initial begin
        #(20 * 600000);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        bit arq_tab[N_PHASES];
        int win_tab[N_PHASES];
        int p;
        arq_tab = '{1, 1, 0, 1, 1, 0, 1, 1, 0, 1, 1, 0};
        win_tab = '{32, 8, 32, 1, 63, 5, 0, 20, 63, 32, 3, 1};
        win_tab[7] = $urandom_range(2, 31);
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = arqrw_pkg::CFG_ARQ_ENABLE;
        cfg_wdata   = '0;
        pkt_valid   = 1'b0;
        pkt_seq     = '0;
        res_ready   = 1'b0;
        idle_on     = 1'b1;
        hold_left   = 0;
        worst_stall = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: old, new, beyond a window of one
        send_seq(16'd0);
        send_seq(16'd1);
        send_seq(16'd3);
        write_reg(arqrw_pkg::CFG_RX_WINDOW, 6'd32);
        // out of order, duplicate of a held number, then the head closes the run
        send_seq(16'd4);
        send_seq(16'd3);
        send_seq(16'd4);
        send_seq(16'd2);
        send_seq(16'd36);
        send_seq(16'd37);
        send_seq(16'd10);
        // plain mode flushes held numbers, reports gaps, wraps the counter
        write_reg(arqrw_pkg::CFG_ARQ_ENABLE, 6'd0);
        send_seq(16'd8);
        send_seq(16'd20);
        send_seq(16'd37);
        send_seq(16'hFFFF);
        send_seq(16'hFFFF);
        send_seq(16'd0);
        send_seq(16'd65533);
        // windowed delivery across the wrap
        write_reg(arqrw_pkg::CFG_ARQ_ENABLE, 6'd1);
        send_seq(16'hFFFF);
        send_seq(16'd65534);
        send_seq(16'd3);
        // plain delivery of a number already held
        write_reg(arqrw_pkg::CFG_ARQ_ENABLE, 6'd0);
        send_seq(16'd3);
        write_reg(arqrw_pkg::CFG_ARQ_ENABLE, 6'd1);
        write_reg(arqrw_pkg::CFG_RX_WINDOW, 6'd0);
        send_seq(16'd4);
        send_seq(16'd2);
        write_reg(arqrw_pkg::CFG_RX_WINDOW, 6'd63);
        send_seq(16'd36);
        send_seq(16'd35);

        for (p = 0; p < N_PHASES; p++) begin
            idle_on = (p != 2);
            if (p == 4) begin
                wait_drain();
                hold_left = HOLD_LEN;
            end
            run_phase(arq_tab[p], win_tab[p], PHASE_LEN);
        end
        idle_on = 1'b1;

        wait_drain();
        repeat (20) @(posedge clk);
        if (sb.pending.size() != 0) begin
            $display("%0d expected beats never arrived", sb.pending.size());
            sb.mismatches += sb.pending.size();
        end
        $display("covered %0d packets over %0d register writes: %0d deliveries, %0d acks,",
                 sb.packets, sb.cfg_writes, sb.deliveries, sb.acks);
        $display("%0d drops, largest result burst per packet %0d, longest input stall %0d cycles",
                 sb.drops, sb.longest_burst, worst_stall);
        if (sb.mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
